FILE: hw/rtl/wrld_pkg.sv
// ----------------------------------------------------------------------------
// wrld_pkg
// shared widths, payload and configuration types, register map and pipeline
// stage counts for the wind relative drag datapath
// ----------------------------------------------------------------------------
package wrld_pkg;

   // vector and coefficient widths
   localparam int NUM_AXES = 3;
   localparam int VEL_W    = 32;
   localparam int PAR_W    = 31;

   // square root: 66 bit sum of squares, 33 bit root, partial remainder
   localparam int RAD_W  = 66;
   localparam int ROOT_W = 33;
   localparam int REM_W  = 36;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // reset values of the coefficient registers
   localparam logic [PAR_W-1:0] DENSITY_RESET = 31'd65536;
   localparam logic [PAR_W-1:0] DRAG_RESET    = 31'd0;
   localparam logic [PAR_W-1:0] STEP_RESET    = 31'd655;

   // stage counts of each unit
   localparam int LAT_SQSUM = 3;
   localparam int LAT_ISQRT = ROOT_W;
   localparam int LAT_DRAG  = 7;
   localparam int LAT_SCALE = 2;
   localparam int LATENCY   = LAT_SQSUM + LAT_ISQRT + LAT_DRAG + LAT_SCALE;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIND_X  = 3'd0,
      CSR_WIND_Y  = 3'd1,
      CSR_WIND_Z  = 3'd2,
      CSR_DENSITY = 3'd3,
      CSR_DRAG    = 3'd4,
      CSR_STEP    = 3'd5
   } csr_index_type;

   // relative velocity as sign and magnitude per axis
   typedef struct packed {
      logic [NUM_AXES-1:0]            neg;
      logic [NUM_AXES-1:0][VEL_W-1:0] mag;
   } rel_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [NUM_AXES-1:0][VEL_W-1:0] wind;
      logic [PAR_W-1:0]               density;
      logic [PAR_W-1:0]               drag;
      logic [PAR_W-1:0]               step;
   } cfg_type;

endpackage

FILE: hw/rtl/wrld_sqsum.sv
// ----------------------------------------------------------------------------
// wrld_sqsum
// relative velocity against the wind, per axis squares and their 66 bit sum
// in three register stages
// ----------------------------------------------------------------------------
module wrld_sqsum
   import wrld_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [NUM_AXES-1:0][VEL_W-1:0] in_vel,
   input  cfg_type                        cfg,
   output logic                           out_valid,
   output rel_type                        out_rel,
   output logic [RAD_W-1:0]               out_sum
);

   logic [NUM_AXES-1:0][VEL_W:0]     diff;
   rel_type                          rel_in;
   rel_type                          rel_a_ff;
   rel_type                          rel_b_ff;
   rel_type                          rel_c_ff;
   logic                             valid_a_ff;
   logic                             valid_b_ff;
   logic                             valid_c_ff;
   logic [NUM_AXES-1:0][2*VEL_W-1:0] sq_in;
   logic [NUM_AXES-1:0][2*VEL_W-1:0] sq_ff;
   logic [RAD_W-1:0]                 sum_in;
   logic [RAD_W-1:0]                 sum_ff;

   // 33 bit difference, split into sign and magnitude
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         diff[i] = {in_vel[i][VEL_W-1], in_vel[i]} - {cfg.wind[i][VEL_W-1], cfg.wind[i]};
         rel_in.neg[i] = diff[i][VEL_W];
         rel_in.mag[i] = diff[i][VEL_W] ? VEL_W'(-diff[i]) : diff[i][VEL_W-1:0];
      end
   end

   // squares of the magnitudes
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         sq_in[i] = rel_a_ff.mag[i] * rel_a_ff.mag[i];
      end
   end

   // exact sum of squares
   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         sum_in = sum_in + RAD_W'(sq_ff[i]);
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= in_valid;
         valid_b_ff <= valid_a_ff;
         valid_c_ff <= valid_b_ff;
      end
      rel_a_ff <= rel_in;
      rel_b_ff <= rel_a_ff;
      rel_c_ff <= rel_b_ff;
      sq_ff    <= sq_in;
      sum_ff   <= sum_in;
   end

   assign out_valid = valid_c_ff;
   assign out_rel   = rel_c_ff;
   assign out_sum   = sum_ff;

endmodule

FILE: hw/rtl/wrld_isqrt.sv
// ----------------------------------------------------------------------------
// wrld_isqrt
// pipelined floor square root, one root bit per stage, 33 stages
// ----------------------------------------------------------------------------
module wrld_isqrt
   import wrld_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rel_type           in_rel,
   input  logic [RAD_W-1:0]  in_rad,
   output logic              out_valid,
   output rel_type           out_rel,
   output logic [ROOT_W-1:0] out_root
);

   logic              vld_ff  [LAT_ISQRT];
   logic [REM_W-1:0]  rem_ff  [LAT_ISQRT];
   logic [ROOT_W-1:0] root_ff [LAT_ISQRT];
   logic [RAD_W-1:0]  rad_ff  [LAT_ISQRT];
   rel_type           rel_ff  [LAT_ISQRT];

   for (genvar k = 0; k < LAT_ISQRT; k++) begin : g_stage
      logic              vld_prv;
      logic [REM_W-1:0]  rem_prv;
      logic [ROOT_W-1:0] root_prv;
      logic [RAD_W-1:0]  rad_prv;
      rel_type           rel_prv;
      logic [REM_W-1:0]  cand;
      logic [REM_W-1:0]  trial;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      // first stage starts from an empty remainder and root
      if (k == 0) begin : g_first
         assign vld_prv  = in_valid;
         assign rem_prv  = '0;
         assign root_prv = '0;
         assign rad_prv  = in_rad;
         assign rel_prv  = in_rel;
      end else begin : g_next
         assign vld_prv  = vld_ff[k-1];
         assign rem_prv  = rem_ff[k-1];
         assign root_prv = root_ff[k-1];
         assign rad_prv  = rad_ff[k-1];
         assign rel_prv  = rel_ff[k-1];
      end

      // bring down the next two radicand bits and try root bit one
      assign cand    = {rem_prv[REM_W-3:0], rad_prv[RAD_W-1 -: 2]};
      assign trial   = (REM_W'(root_prv) << 2) | REM_W'(1);
      assign ge      = cand >= trial;
      assign rem_in  = ge ? cand - trial : cand;
      assign root_in = {root_prv[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_prv;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_prv << 2;
         rel_ff[k]  <= rel_prv;
      end
   end

   assign out_valid = vld_ff[LAT_ISQRT-1];
   assign out_rel   = rel_ff[LAT_ISQRT-1];
   assign out_root  = root_ff[LAT_ISQRT-1];

endmodule

FILE: hw/rtl/wrld_drag.sv
// ----------------------------------------------------------------------------
// wrld_drag
// drag product length * density * drag * step and the remaining fraction,
// seven register stages with split multiplies for the wide operands
// ----------------------------------------------------------------------------
module wrld_drag
   import wrld_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  rel_type           in_rel,
   input  logic [ROOT_W-1:0] in_root,
   input  cfg_type           cfg,
   output logic              out_valid,
   output rel_type           out_rel,
   output logic [FRAC_BITS:0] out_remain,
   output logic              out_stop
);

   localparam int F       = FRAC_BITS;
   localparam int PROD1_W = ROOT_W + PAR_W;
   // first product is exact below 2^(3F), which is all a later stop needs
   localparam int W1      = (PROD1_W - F < 3*F + 1) ? PROD1_W - F : 3*F + 1;
   localparam int H1      = (W1 + 1) / 2;
   localparam int S2_W    = W1 + PAR_W;
   // second product is exact below 2^(2F)
   localparam int W2      = (S2_W - F < 2*F + 1) ? S2_W - F : 2*F + 1;
   localparam int H2      = (W2 + 1) / 2;
   localparam int S3_W    = W2 + PAR_W;

   localparam logic [W1-1:0] CAP1 = W1'(1) << (3*F);
   localparam logic [W2-1:0] CAP2 = W2'(1) << (2*F);
   localparam logic [F:0]    ONE  = (F+1)'(1) << F;

   logic                    vld_ff [LAT_DRAG];
   rel_type                 rel_ff [LAT_DRAG];

   logic [PROD1_W-1:0]      prod1_in;
   logic [PROD1_W-1:0]      prod1_ff;
   logic                    over1;
   logic [W1-1:0]           p1_in;
   logic [W1-1:0]           p1_ff;
   logic [H1+PAR_W-1:0]     pl2_in;
   logic [H1+PAR_W-1:0]     pl2_ff;
   logic [W1-H1+PAR_W-1:0]  ph2_in;
   logic [W1-H1+PAR_W-1:0]  ph2_ff;
   logic [S2_W-1:0]         s2;
   logic                    over2;
   logic [W2-1:0]           p2_in;
   logic [W2-1:0]           p2_ff;
   logic [H2+PAR_W-1:0]     pl3_in;
   logic [H2+PAR_W-1:0]     pl3_ff;
   logic [W2-H2+PAR_W-1:0]  ph3_in;
   logic [W2-H2+PAR_W-1:0]  ph3_ff;
   logic [S3_W-1:0]         s3;
   logic                    stop6_in;
   logic                    stop6_ff;
   logic [F-1:0]            frac6_in;
   logic [F-1:0]            frac6_ff;
   logic [F:0]              remain_in;
   logic [F:0]              remain_ff;
   logic                    stop7_ff;

   // length times density
   assign prod1_in = in_root * cfg.density;

   // drop fraction bits, clamp where the product already forces a stop
   assign over1 = |(prod1_ff >> (4*F));
   assign p1_in = over1 ? CAP1 : W1'(prod1_ff >> F);

   // times drag, as two partial products
   assign pl2_in = p1_ff[H1-1:0] * cfg.drag;
   assign ph2_in = p1_ff[W1-1:H1] * cfg.drag;

   // join partials, drop fraction bits and clamp
   assign s2    = (S2_W'(ph2_ff) << H1) + S2_W'(pl2_ff);
   assign over2 = |(s2 >> (3*F));
   assign p2_in = over2 ? CAP2 : W2'(s2 >> F);

   // times step, as two partial products
   assign pl3_in = p2_ff[H2-1:0] * cfg.step;
   assign ph3_in = p2_ff[W2-1:H2] * cfg.step;

   // join partials, test for a product of one or more
   assign s3       = (S3_W'(ph3_ff) << H2) + S3_W'(pl3_ff);
   assign stop6_in = |(s3 >> (2*F));
   assign frac6_in = F'(s3 >> F);

   // remaining fraction, zero once stopped
   assign remain_in = stop6_ff ? '0 : ONE - (F+1)'(frac6_ff);

   // valid and payload travel alongside
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT_DRAG; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k < LAT_DRAG; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      rel_ff[0] <= in_rel;
      for (int k = 1; k < LAT_DRAG; k++) begin
         rel_ff[k] <= rel_ff[k-1];
      end
   end

   // datapath stage registers
   always_ff @(posedge clock) begin
      prod1_ff  <= prod1_in;
      p1_ff     <= p1_in;
      pl2_ff    <= pl2_in;
      ph2_ff    <= ph2_in;
      p2_ff     <= p2_in;
      pl3_ff    <= pl3_in;
      ph3_ff    <= ph3_in;
      stop6_ff  <= stop6_in;
      frac6_ff  <= frac6_in;
      remain_ff <= remain_in;
      stop7_ff  <= stop6_ff;
   end

   assign out_valid  = vld_ff[LAT_DRAG-1];
   assign out_rel    = rel_ff[LAT_DRAG-1];
   assign out_remain = remain_ff;
   assign out_stop   = stop7_ff;

endmodule

FILE: hw/rtl/wrld_scale.sv
// ----------------------------------------------------------------------------
// wrld_scale
// scales the relative vector by the remaining fraction, adds the wind back
// and saturates to 32 bits, two register stages
// ----------------------------------------------------------------------------
module wrld_scale
   import wrld_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  rel_type                        in_rel,
   input  logic [FRAC_BITS:0]             in_remain,
   input  logic                           in_stop,
   input  cfg_type                        cfg,
   output logic                           out_valid,
   output logic [NUM_AXES-1:0][VEL_W-1:0] out_vel,
   output logic                           out_stop
);

   localparam int F      = FRAC_BITS;
   localparam int PROD_W = VEL_W + F + 1;
   localparam int SUM_W  = VEL_W + 2;

   localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
   localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

   logic [NUM_AXES-1:0][PROD_W-1:0] prod_in;
   logic [NUM_AXES-1:0][PROD_W-1:0] prod_ff;
   logic [NUM_AXES-1:0]             neg1_ff;
   logic                            valid1_ff;
   logic                            stop1_ff;
   logic [NUM_AXES-1:0][VEL_W-1:0]  mag;
   logic [NUM_AXES-1:0][SUM_W-1:0]  wind_ext;
   logic [NUM_AXES-1:0][SUM_W-1:0]  sum;
   logic [NUM_AXES-1:0][VEL_W-1:0]  vel_in;
   logic [NUM_AXES-1:0][VEL_W-1:0]  vel_ff;
   logic                            valid2_ff;
   logic                            stop2_ff;

   // magnitude times remaining fraction
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         prod_in[i] = in_rel.mag[i] * in_remain;
      end
   end

   // truncate toward zero, restore sign, add wind, saturate
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         mag[i]      = VEL_W'(prod_ff[i] >> F);
         wind_ext[i] = {{2{cfg.wind[i][VEL_W-1]}}, cfg.wind[i]};
         sum[i]      = neg1_ff[i] ? wind_ext[i] - SUM_W'(mag[i])
                                  : wind_ext[i] + SUM_W'(mag[i]);
         if (sum[i][SUM_W-1:VEL_W-1] == '0 || sum[i][SUM_W-1:VEL_W-1] == '1) begin
            vel_in[i] = sum[i][VEL_W-1:0];
         end else if (sum[i][SUM_W-1]) begin
            vel_in[i] = VEL_MIN;
         end else begin
            vel_in[i] = VEL_MAX;
         end
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
      prod_ff  <= prod_in;
      neg1_ff  <= in_rel.neg;
      stop1_ff <= in_stop;
      vel_ff   <= vel_in;
      stop2_ff <= stop1_ff;
   end

   assign out_valid = valid2_ff;
   assign out_vel   = vel_ff;
   assign out_stop  = stop2_ff;

endmodule

FILE: hw/rtl/wind_relative_linear_drag.sv
// ----------------------------------------------------------------------------
// wind_relative_linear_drag
// path from start to rsp_valid: squares, square root, drag and output stages
// throughput: one item per cycle outside reset; the 33 stage square root pipeline sets depth
// busy is high only during reset; results cannot be held off by the receiver
// synchronous reset clears all valid bits and loads the register defaults
// ----------------------------------------------------------------------------
module wind_relative_linear_drag
   import wrld_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VEL_W-1:0]       req_vel_in_x,
   input  logic [VEL_W-1:0]       req_vel_in_y,
   input  logic [VEL_W-1:0]       req_vel_in_z,
   output logic                   rsp_valid,
   output logic [VEL_W-1:0]       rsp_vel_out_x,
   output logic [VEL_W-1:0]       rsp_vel_out_y,
   output logic [VEL_W-1:0]       rsp_vel_out_z,
   output logic                   rsp_fully_stopped,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type                        cfg_ff;
   logic                           req_transfer;
   logic [NUM_AXES-1:0][VEL_W-1:0] req_vel;
   logic                           sq_valid;
   rel_type                        sq_rel;
   logic [RAD_W-1:0]               sq_sum;
   logic                           rt_valid;
   rel_type                        rt_rel;
   logic [ROOT_W-1:0]              rt_root;
   logic                           dg_valid;
   rel_type                        dg_rel;
   logic [FRAC_BITS:0]             dg_remain;
   logic                           dg_stop;
   logic [NUM_AXES-1:0][VEL_W-1:0] out_vel;

   // pipeline takes an item every cycle outside reset
   assign busy         = reset;
   assign req_transfer = start & ~busy;
   assign req_vel      = {req_vel_in_z, req_vel_in_y, req_vel_in_x};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wind    <= '0;
         cfg_ff.density <= DENSITY_RESET;
         cfg_ff.drag    <= DRAG_RESET;
         cfg_ff.step    <= STEP_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIND_X:  cfg_ff.wind[0] <= csr_wdata[VEL_W-1:0];
            CSR_WIND_Y:  cfg_ff.wind[1] <= csr_wdata[VEL_W-1:0];
            CSR_WIND_Z:  cfg_ff.wind[2] <= csr_wdata[VEL_W-1:0];
            CSR_DENSITY: cfg_ff.density <= csr_wdata[PAR_W-1:0];
            CSR_DRAG:    cfg_ff.drag    <= csr_wdata[PAR_W-1:0];
            CSR_STEP:    cfg_ff.step    <= csr_wdata[PAR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // relative vector and sum of squares
   wrld_sqsum u_sqsum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_transfer),
      .in_vel    (req_vel),
      .cfg       (cfg_ff),
      .out_valid (sq_valid),
      .out_rel   (sq_rel),
      .out_sum   (sq_sum)
   );

   // euclidean length
   wrld_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_rel    (sq_rel),
      .in_rad    (sq_sum),
      .out_valid (rt_valid),
      .out_rel   (rt_rel),
      .out_root  (rt_root)
   );

   // drag product and remaining fraction
   wrld_drag #(
      .FRAC_BITS (FRAC_BITS)
   ) u_drag (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (rt_valid),
      .in_rel     (rt_rel),
      .in_root    (rt_root),
      .cfg        (cfg_ff),
      .out_valid  (dg_valid),
      .out_rel    (dg_rel),
      .out_remain (dg_remain),
      .out_stop   (dg_stop)
   );

   // damped vector plus wind
   wrld_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dg_valid),
      .in_rel    (dg_rel),
      .in_remain (dg_remain),
      .in_stop   (dg_stop),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_vel   (out_vel),
      .out_stop  (rsp_fully_stopped)
   );

   assign rsp_vel_out_x = out_vel[0];
   assign rsp_vel_out_y = out_vel[1];
   assign rsp_vel_out_z = out_vel[2];

   // every result comes from a transfer a fixed latency earlier
   a_result_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_transfer, LATENCY))
      else $error("result without a matching input transfer");

   // every transfer yields a result after the fixed latency
   a_transfer_has_result: assert property (@(posedge clock) disable iff (reset)
      req_transfer |-> ##LATENCY rsp_valid)
      else $error("input transfer produced no result");

   // a full stop leaves only the wind
   a_stop_gives_wind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_fully_stopped) |->
         (rsp_vel_out_x == cfg_ff.wind[0] && rsp_vel_out_y == cfg_ff.wind[1] &&
          rsp_vel_out_z == cfg_ff.wind[2]))
      else $error("stopped result differs from the wind");

   // no drag, no stop
   a_no_drag_no_stop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cfg_ff.drag == '0) |-> !rsp_fully_stopped)
      else $error("stop flagged with zero drag");

endmodule
